// ===== hw/rtl/eight_bit_isa_executor_defines.svh =====
// Assertion macros shared by the eight-bit instruction executor.
`ifndef EIGHT_BIT_ISA_EXECUTOR_DEFINES_SVH
`define EIGHT_BIT_ISA_EXECUTOR_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define EIBX_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define EIBX_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/eibx_pkg.sv =====
// Shared types, codes and helpers of the eight-bit instruction executor.
package eibx_pkg;

   localparam int unsigned BYTE_W             = 8;
   localparam int unsigned REG_COUNT          = 16;
   localparam int unsigned REG_AW             = $clog2(REG_COUNT);
   localparam int unsigned ADDR_SPAN          = 256;
   localparam int unsigned DATA_DEPTH_DEFAULT = 256;
   localparam int unsigned REQ_TDATA_W        = 32;
   localparam int unsigned REQ_TUSER_W        = 3;
   localparam int unsigned RSP_TDATA_W        = 48;
   localparam int unsigned RSP_TUSER_W        = 5;

   // Request kinds.
   localparam logic [2:0] REQ_EXEC     = 3'd0;
   localparam logic [2:0] REQ_LOAD_MEM = 3'd1;
   localparam logic [2:0] REQ_LOAD_REG = 3'd2;
   localparam logic [2:0] REQ_READ_MEM = 3'd3;
   localparam logic [2:0] REQ_READ_REG = 3'd4;

   // Opcodes.
   localparam logic [3:0] OP_ADD   = 4'd0;
   localparam logic [3:0] OP_SUB   = 4'd1;
   localparam logic [3:0] OP_MUL   = 4'd2;
   localparam logic [3:0] OP_INC   = 4'd3;
   localparam logic [3:0] OP_AND   = 4'd4;
   localparam logic [3:0] OP_OR    = 4'd5;
   localparam logic [3:0] OP_XOR   = 4'd6;
   localparam logic [3:0] OP_NOT   = 4'd7;
   localparam logic [3:0] OP_SHL   = 4'd8;
   localparam logic [3:0] OP_SHR   = 4'd9;
   localparam logic [3:0] OP_LI    = 4'd10;
   localparam logic [3:0] OP_LOAD  = 4'd11;
   localparam logic [3:0] OP_STORE = 4'd12;
   localparam logic [3:0] OP_JUMP  = 4'd13;
   localparam logic [3:0] OP_BRZ   = 4'd14;
   localparam logic [3:0] OP_HALT  = 4'd15;

   // Instruction classes.
   localparam logic [2:0] CLS_NONE    = 3'd0;
   localparam logic [2:0] CLS_ARITH   = 3'd1;
   localparam logic [2:0] CLS_LOGIC   = 3'd2;
   localparam logic [2:0] CLS_SHIFT   = 3'd3;
   localparam logic [2:0] CLS_MEMORY  = 3'd4;
   localparam logic [2:0] CLS_LOADIMM = 3'd5;
   localparam logic [2:0] CLS_CONTROL = 3'd6;
   localparam logic [2:0] CLS_HALT    = 3'd7;

   typedef logic [BYTE_W-1:0] byte_type;

   typedef struct packed {
      logic [3:0] op;
      byte_type   x;
      byte_type   y;
      logic [3:0] sh;
      byte_type   imm;
   } alu_req_type;

   typedef struct packed {
      logic              en;
      logic [REG_AW-1:0] addr;
      byte_type          data;
   } rf_wr_type;

   // Result beat payload; the last member sits in the lowest bits.
   typedef struct packed {
      logic [2:0]        pad;
      byte_type          read_data;
      byte_type          mem_data;
      byte_type          mem_address;
      byte_type          reg_data;
      logic [REG_AW-1:0] reg_number;
      logic              halted;
      byte_type          next_pc;
   } rsp_data_type;

   typedef struct packed {
      logic [2:0] instr_class;
      logic       mem_written;
      logic       reg_written;
   } rsp_user_type;

   function automatic logic [2:0] op_class(input logic [3:0] op);
      logic [2:0] cls;
      unique case (op)
         OP_ADD, OP_SUB, OP_MUL, OP_INC: cls = CLS_ARITH;
         OP_AND, OP_OR, OP_XOR, OP_NOT:  cls = CLS_LOGIC;
         OP_SHL, OP_SHR:                 cls = CLS_SHIFT;
         OP_LI:                          cls = CLS_LOADIMM;
         OP_LOAD, OP_STORE:              cls = CLS_MEMORY;
         OP_JUMP, OP_BRZ:                cls = CLS_CONTROL;
         default:                        cls = CLS_HALT;
      endcase
      return cls;
   endfunction

endpackage

// ===== hw/rtl/eibx_regfile.sv =====
// Register file: sixteen bytes, two registered read ports, one write port.
module eibx_regfile import eibx_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_en,
   input  logic [REG_AW-1:0] rd_addr0,
   input  logic [REG_AW-1:0] rd_addr1,
   output byte_type          rd_data0,
   output byte_type          rd_data1,
   input  rf_wr_type         wr
);

   byte_type               mem [REG_COUNT];
   logic [REG_COUNT-1:0]   valid_ff, valid_in;
   byte_type               rdata0_ff, rdata1_ff;
   logic                   rvalid0_ff, rvalid0_in;
   logic                   rvalid1_ff, rvalid1_in;

   // An entry never written reads as zero.
   always_comb begin
      valid_in = valid_ff;
      if (wr.en) begin
         valid_in[wr.addr] = 1'b1;
      end
      rvalid0_in = rd_en ? valid_ff[rd_addr0] : rvalid0_ff;
      rvalid1_in = rd_en ? valid_ff[rd_addr1] : rvalid1_ff;
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rdata0_ff <= mem[rd_addr0];
         rdata1_ff <= mem[rd_addr1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         rvalid0_ff <= 1'b0;
         rvalid1_ff <= 1'b0;
      end else begin
         valid_ff   <= valid_in;
         rvalid0_ff <= rvalid0_in;
         rvalid1_ff <= rvalid1_in;
      end
   end

   assign rd_data0 = rvalid0_ff ? rdata0_ff : '0;
   assign rd_data1 = rvalid1_ff ? rdata1_ff : '0;

endmodule

// ===== hw/rtl/eibx_datamem.sv =====
// Data memory: one registered read port and one write port, zero until written.
module eibx_datamem import eibx_pkg::*; #(
   parameter  int unsigned DATA_DEPTH = DATA_DEPTH_DEFAULT,
   localparam int unsigned IDX_W      = $clog2(DATA_DEPTH)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             rd_en,
   input  logic [IDX_W-1:0] rd_addr,
   output byte_type         rd_data,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  byte_type         wr_data
);

   byte_type              mem [DATA_DEPTH];
   logic [DATA_DEPTH-1:0] valid_ff, valid_in;
   byte_type              rdata_ff;
   logic                  rvalid_ff, rvalid_in;

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
      rvalid_in = rd_en ? valid_ff[rd_addr] : rvalid_ff;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         rvalid_ff <= rvalid_in;
      end
   end

   assign rd_data = rvalid_ff ? rdata_ff : '0;

endmodule

// ===== hw/rtl/eibx_alu.sv =====
// Byte ALU for the register-to-register and load-immediate opcodes.
module eibx_alu import eibx_pkg::*; (
   input  alu_req_type req,
   output byte_type    res
);

   logic [2*BYTE_W-1:0] product;

   assign product = req.x * req.y;

   always_comb begin
      unique case (req.op)
         OP_ADD:  res = req.x + req.y;
         OP_SUB:  res = req.x - req.y;
         OP_MUL:  res = product[BYTE_W-1:0];
         OP_INC:  res = req.x + 8'd1;
         OP_AND:  res = req.x & req.y;
         OP_OR:   res = req.x | req.y;
         OP_XOR:  res = req.x ^ req.y;
         OP_NOT:  res = ~req.x;
         OP_SHL:  res = req.x << req.sh;
         OP_SHR:  res = req.x >> req.sh;
         OP_LI:   res = req.imm;
         default: res = '0;
      endcase
   end

endmodule

// ===== hw/rtl/eight_bit_isa_executor.sv =====
// Top level of the eight-bit instruction executor: pipeline, state and stream ports.
//
//   Channel | Dir | Handshake             | tdata                           | tuser
//   req     | in  | req_tvalid/req_tready | instruction, target, load value | request kind
//   rsp     | out | rsp_tvalid/rsp_tready | pc, halted, writes, read data   | write flags, class
//
// One beat is accepted per cycle while results are taken. The register read overlaps the
// accept edge, execute and the data memory access happen in S1, write-back in S2, and the
// result beat is then presented from the output register S3.
// Synchronous reset clears the pc, the halt flag, the pipeline valids and the per-entry
// valid bits of both memories; there is no clearing pass.
// A stalled result beat freezes the whole pipeline, so req_tready = !rsp_tvalid || rsp_tready.
`include "eight_bit_isa_executor_defines.svh"

module eight_bit_isa_executor import eibx_pkg::*; #(
   parameter int unsigned DATA_DEPTH = DATA_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // instruction [15:0], target_index [23:16], load_value [31:24]
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // req_type [2:0]
   input  logic [REQ_TUSER_W-1:0] req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // next_pc [7:0], halted [8], reg_number [12:9], reg_data [20:13],
   // mem_address [28:21], mem_data [36:29], read_data [44:37], zero fill [47:45]
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // reg_written [0], mem_written [1], instr_class [4:2]
   output logic [RSP_TUSER_W-1:0] rsp_tuser
);

   localparam int unsigned IDX_W = $clog2(DATA_DEPTH);

   // Pipeline advance: every stage moves together when the output register frees up.
   logic adv;

   // Request beat fields.
   logic [2:0]   in_type;
   logic [15:0]  in_instr;
   byte_type     in_tgt;
   byte_type     in_lv;
   logic [3:0]   in_op;
   logic [REG_AW-1:0] rf_raddr0, rf_raddr1;

   // Register read stage (S1).
   logic              s1_valid_ff;
   logic [2:0]        s1_type_ff;
   logic [15:0]       s1_instr_ff;
   byte_type          s1_tgt_ff;
   byte_type          s1_lv_ff;
   logic [REG_AW-1:0] s1_raddr0_ff, s1_raddr1_ff;

   // Architectural program counter and halt flag.
   byte_type pc_ff, pc_in;
   logic     halt_ff, halt_in;

   // Memory access stage (S2).
   logic              s2_valid_ff;
   logic              s2_rw_ff;
   logic [REG_AW-1:0] s2_rn_ff;
   byte_type          s2_res_ff;
   logic              s2_load_ff;
   logic              s2_mw_ff;
   byte_type          s2_ma_ff;
   byte_type          s2_md_ff;
   logic              s2_rsel_mem_ff;
   byte_type          s2_rdata_ff;
   logic [2:0]        s2_cls_ff;
   byte_type          s2_pc_ff;
   logic              s2_halt_ff;
   byte_type          s2_wdata;

   // Write that reached the register file at the last advance.
   logic              wb_valid_ff;
   logic [REG_AW-1:0] wb_addr_ff;
   byte_type          wb_data_ff;

   // Output register (S3).
   logic         s3_valid_ff;
   rsp_data_type s3_data_ff, s3_data_in;
   rsp_user_type s3_user_ff, s3_user_in;
   logic         s3_two_wr;

   // Execute-stage signals.
   byte_type          rf_rdata0, rf_rdata1;
   byte_type          opa, opb;
   logic [3:0]        s1_op;
   logic [REG_AW-1:0] s1_rd;
   byte_type          s1_imm;
   logic              s1_exec;
   alu_req_type       alu_req;
   byte_type          alu_res;
   byte_type          eff_addr;
   logic [IDX_W-1:0]  dm_idx;
   byte_type          seq_pc, jmp_pc;
   logic              x_rw, x_load, x_mw, x_rsel_mem;
   logic [REG_AW-1:0] x_rn;
   byte_type          x_res, x_md, x_rdata;
   logic [2:0]        x_cls;
   byte_type          dm_rdata;
   rf_wr_type         rf_wr;

   // Byte address folded onto the data memory depth.
   logic [IDX_W-1:0] idx_table [ADDR_SPAN];

   for (genvar g = 0; g < ADDR_SPAN; g++) begin : g_idx
      assign idx_table[g] = IDX_W'(g % DATA_DEPTH);
   end

   assign adv        = !s3_valid_ff || rsp_tready;
   assign req_tready = adv;

   // Operand read addresses are decoded straight from the request beat, so the
   // register file read overlaps the accept edge.
   assign in_type  = req_tuser;
   assign in_instr = req_tdata[15:0];
   assign in_tgt   = req_tdata[23:16];
   assign in_lv    = req_tdata[31:24];
   assign in_op    = in_instr[15:12];

   always_comb begin
      if (in_type == REQ_READ_REG) begin
         rf_raddr0 = in_tgt[REG_AW-1:0];
      end else if (in_op == OP_INC || in_op == OP_STORE || in_op == OP_BRZ) begin
         rf_raddr0 = in_instr[11:8];
      end else begin
         rf_raddr0 = in_instr[7:4];
      end
      rf_raddr1 = (in_op == OP_STORE) ? in_instr[7:4] : in_instr[3:0];
   end

   eibx_regfile u_regfile (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (adv),
      .rd_addr0 (rf_raddr0),
      .rd_addr1 (rf_raddr1),
      .rd_data0 (rf_rdata0),
      .rd_data1 (rf_rdata1),
      .wr       (rf_wr)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_type_ff   <= in_type;
         s1_instr_ff  <= in_instr;
         s1_tgt_ff    <= in_tgt;
         s1_lv_ff     <= in_lv;
         s1_raddr0_ff <= rf_raddr0;
         s1_raddr1_ff <= rf_raddr1;
      end
   end

   // A load's byte comes out of the data memory one stage later, so the write-back
   // value of S2 is picked there.
   assign s2_wdata = s2_load_ff ? dm_rdata : s2_res_ff;

   // Forwarding: the write still in S2 is newest, then the write committed at the
   // edge where this beat's operands were read, then the register file itself.
   always_comb begin
      if (s2_valid_ff && s2_rw_ff && s2_rn_ff == s1_raddr0_ff) begin
         opa = s2_wdata;
      end else if (wb_valid_ff && wb_addr_ff == s1_raddr0_ff) begin
         opa = wb_data_ff;
      end else begin
         opa = rf_rdata0;
      end
      if (s2_valid_ff && s2_rw_ff && s2_rn_ff == s1_raddr1_ff) begin
         opb = s2_wdata;
      end else if (wb_valid_ff && wb_addr_ff == s1_raddr1_ff) begin
         opb = wb_data_ff;
      end else begin
         opb = rf_rdata1;
      end
   end

   assign s1_op   = s1_instr_ff[15:12];
   assign s1_rd   = s1_instr_ff[11:8];
   assign s1_imm  = s1_instr_ff[7:0];
   assign s1_exec = s1_valid_ff && s1_type_ff == REQ_EXEC && !halt_ff;

   assign alu_req = '{op: s1_op, x: opa, y: opb, sh: s1_instr_ff[3:0], imm: s1_imm};

   eibx_alu u_alu (
      .req (alu_req),
      .res (alu_res)
   );

   // Load and store address a base register plus the signed byte offset; setup beats
   // address memory directly.
   assign eff_addr = (s1_type_ff == REQ_EXEC) ? opa + s1_imm : s1_tgt_ff;
   assign dm_idx   = idx_table[eff_addr];

   // Branch target is the sequential pc plus twice the signed offset, modulo 256.
   assign seq_pc = pc_ff + 8'd2;
   assign jmp_pc = seq_pc + {s1_imm[6:0], 1'b0};

   always_comb begin
      pc_in      = pc_ff;
      halt_in    = halt_ff;
      x_rw       = 1'b0;
      x_rn       = '0;
      x_res      = '0;
      x_load     = 1'b0;
      x_mw       = 1'b0;
      x_md       = '0;
      x_rsel_mem = 1'b0;
      x_rdata    = '0;
      x_cls      = CLS_NONE;
      if (s1_valid_ff) begin
         unique case (s1_type_ff)
            REQ_EXEC: begin
               // An execute beat after halt changes nothing and reports class none.
               if (!halt_ff) begin
                  x_cls = op_class(s1_op);
                  pc_in = seq_pc;
                  if (s1_op <= OP_LOAD) begin
                     x_rw   = 1'b1;
                     x_rn   = s1_rd;
                     x_res  = alu_res;
                     x_load = (s1_op == OP_LOAD);
                  end
                  if (s1_op == OP_STORE) begin
                     x_mw = 1'b1;
                     x_md = opb;
                  end
                  if (s1_op == OP_JUMP || (s1_op == OP_BRZ && opa == '0)) begin
                     pc_in = jmp_pc;
                  end
                  if (s1_op == OP_HALT) begin
                     halt_in = 1'b1;
                  end
               end
            end
            REQ_LOAD_MEM: begin
               x_mw = 1'b1;
               x_md = s1_lv_ff;
            end
            REQ_LOAD_REG: begin
               x_rw  = 1'b1;
               x_rn  = s1_tgt_ff[REG_AW-1:0];
               x_res = s1_lv_ff;
            end
            REQ_READ_MEM: begin
               x_rsel_mem = 1'b1;
            end
            REQ_READ_REG: begin
               x_rdata = opa;
            end
            default: begin
               // Unknown request kinds report pc and halt only.
            end
         endcase
      end
   end

   // All data memory traffic happens in S1, so accesses stay in program order.
   eibx_datamem #(
      .DATA_DEPTH (DATA_DEPTH)
   ) u_datamem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (adv),
      .rd_addr (dm_idx),
      .rd_data (dm_rdata),
      .wr_en   (adv && x_mw),
      .wr_addr (dm_idx),
      .wr_data (x_md)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_rw_ff       <= x_rw;
         s2_rn_ff       <= x_rn;
         s2_res_ff      <= x_res;
         s2_load_ff     <= x_load;
         s2_mw_ff       <= x_mw;
         s2_ma_ff       <= x_mw ? BYTE_W'(dm_idx) : '0;
         s2_md_ff       <= x_md;
         s2_rsel_mem_ff <= x_rsel_mem;
         s2_rdata_ff    <= x_rdata;
         s2_cls_ff      <= x_cls;
         s2_pc_ff       <= pc_in;
         s2_halt_ff     <= halt_in;
      end
   end

   // Register write-back from S2, including loads and register setup beats.
   assign rf_wr = '{en: adv && s2_valid_ff && s2_rw_ff, addr: s2_rn_ff, data: s2_wdata};

   always_ff @(posedge clock) begin
      if (adv) begin
         wb_addr_ff <= rf_wr.addr;
         wb_data_ff <= rf_wr.data;
      end
   end

   always_comb begin
      s3_data_in.pad         = '0;
      s3_data_in.read_data   = s2_rsel_mem_ff ? dm_rdata : s2_rdata_ff;
      s3_data_in.mem_data    = s2_md_ff;
      s3_data_in.mem_address = s2_ma_ff;
      s3_data_in.reg_data    = s2_rw_ff ? s2_wdata : '0;
      s3_data_in.reg_number  = s2_rn_ff;
      s3_data_in.halted      = s2_halt_ff;
      s3_data_in.next_pc     = s2_pc_ff;
      s3_user_in.instr_class = s2_cls_ff;
      s3_user_in.mem_written = s2_mw_ff;
      s3_user_in.reg_written = s2_rw_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_data_ff <= s3_data_in;
         s3_user_ff <= s3_user_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         wb_valid_ff <= 1'b0;
         pc_ff       <= '0;
         halt_ff     <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_tvalid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         wb_valid_ff <= rf_wr.en;
         pc_ff       <= pc_in;
         halt_ff     <= halt_in;
      end
   end

   assign rsp_tvalid = s3_valid_ff;
   assign rsp_tdata  = s3_data_ff;
   assign rsp_tuser  = s3_user_ff;

   assign s3_two_wr = s3_user_ff.reg_written && s3_user_ff.mem_written;

   // Halt is only cleared by reset.
   `EIBX_ASSERT_NEXT(a_halt_sticky, clock, reset, halt_ff, halt_ff, "halt flag dropped")
   // The program counter moves only when a live execute beat leaves S1.
   `EIBX_ASSERT_NEXT(a_pc_hold, clock, reset, !(adv && s1_exec), $stable(pc_ff), "pc moved")
   // No beat writes both a register and data memory.
   `EIBX_ASSERT_IMPLIES(a_one_write, clock, reset, s3_valid_ff, !s3_two_wr, "double write")

endmodule
